// ----- rtl/kufe_pkg.sv -----
// Shared field widths and controller/datapath interface types for the union-find engine.
package kufe_pkg;

	localparam int WEIGHT_W = 20;
	localparam int NODE_W   = 9;
	localparam int SUM_W    = 32;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load_item;   // latch the input request
		logic find_start;  // begin a root walk at an endpoint
		logic find_sel_b;  // walk starts at node_b instead of node_a
		logic find_step;   // follow one parent link
		logic comp_start;  // begin path compression at the start node
		logic comp_step;   // repoint one node at the root, move to its old parent
		logic save_ra;     // keep the root of node_a
		logic join_sets;   // link the two roots if they differ, add the weight
		logic clr_start;   // rewind the clear counter, zero the sum
		logic clr_write;   // write one identity entry
		logic out_load;    // load the result register
	} kufe_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic in_range;    // both endpoints are below the node count
		logic link_end;    // parent just read ends the chain
		logic at_root;     // compression walk already at the root
		logic clr_last;    // clear counter at the last entry
		logic last_item;   // latched request closes the graph
	} kufe_sts_t;

endpackage

// ----- rtl/kufe_ctrl.sv -----
// Controller state machine: sequences root walks, compression, union and table clearing.
module kufe_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  kufe_pkg::kufe_sts_t sts,
	output kufe_pkg::kufe_cmd_t cmd
);
	import kufe_pkg::*;

	typedef enum logic [7:0] {
		ST_CLEAR  = 8'b0000_0001,
		ST_IDLE   = 8'b0000_0010,
		ST_START  = 8'b0000_0100,
		ST_FIND   = 8'b0000_1000,
		ST_COMP   = 8'b0001_0000,
		ST_NEXT   = 8'b0010_0000,
		ST_JOIN   = 8'b0100_0000,
		ST_RESULT = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;
	logic   side_q, side_d;     // 0: walking node_a, 1: walking node_b
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	// Next state and commands
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		side_d  = side_q;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr_write = 1'b1;
				if (sts.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load_item = 1'b1;
					state_d       = ST_START;
				end
			end
			ST_START: begin
				side_d = 1'b0;
				if (sts.in_range) begin
					cmd.find_start = 1'b1;
					state_d        = ST_FIND;
				end else begin
					state_d = ST_RESULT;
				end
			end
			ST_FIND: begin
				if (sts.link_end) begin
					if (sts.at_root) begin
						state_d = ST_NEXT;
					end else begin
						cmd.comp_start = 1'b1;
						state_d        = ST_COMP;
					end
				end else begin
					cmd.find_step = 1'b1;
				end
			end
			ST_COMP: begin
				cmd.comp_step = 1'b1;
				if (sts.link_end) begin
					state_d = ST_NEXT;
				end
			end
			ST_NEXT: begin
				if (!side_q) begin
					cmd.save_ra    = 1'b1;
					cmd.find_start = 1'b1;
					cmd.find_sel_b = 1'b1;
					side_d         = 1'b1;
					state_d        = ST_FIND;
				end else begin
					state_d = ST_JOIN;
				end
			end
			ST_JOIN: begin
				cmd.join_sets = 1'b1;
				state_d       = ST_RESULT;
			end
			ST_RESULT: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					if (sts.last_item) begin
						cmd.clr_start = 1'b1;
						state_d       = ST_CLEAR;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State registers; reset starts with a clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			side_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			side_q  <= side_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- rtl/kufe_dpath.sv -----
// Datapath: parent memory, walk registers, weight sum and result register.
module kufe_dpath #(
	parameter int MAX_NODES = 512
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [kufe_pkg::WEIGHT_W-1:0] edge_weight,
	input  logic [kufe_pkg::NODE_W-1:0]   node_a,
	input  logic [kufe_pkg::NODE_W-1:0]   node_b,
	input  logic                          last_edge,
	input  kufe_pkg::kufe_cmd_t           cmd,
	output kufe_pkg::kufe_sts_t           sts,
	output logic                          edge_taken,
	output logic [kufe_pkg::SUM_W-1:0]    running_total,
	output logic                          graph_done
);
	import kufe_pkg::*;

	localparam int NW = $clog2(MAX_NODES);

	// Parent table
	logic [NW-1:0] mem [MAX_NODES];
	logic [NW-1:0] rdata_q;
	logic [NW-1:0] raddr, waddr, wdata;
	logic          mem_re, mem_we;

	// Latched request
	logic [WEIGHT_W-1:0] w_q;
	logic [NODE_W-1:0]   a_q, b_q;
	logic                last_q;

	// Walk registers
	logic [NW-1:0] r_q, cur_q, ra_q, start_node;
	logic [NW-1:0] clr_q;
	logic [SUM_W-1:0] sum_q;
	logic          taken_q;
	logic          roots_differ;

	// Result register
	logic             out_taken_q, out_done_q;
	logic [SUM_W-1:0] out_total_q;

	assign start_node   = cmd.find_sel_b ? NW'(b_q) : NW'(a_q);
	assign roots_differ = (ra_q != r_q);

	// Status
	assign sts.in_range  = (32'(a_q) < MAX_NODES) && (32'(b_q) < MAX_NODES);
	assign sts.link_end  = (rdata_q == r_q) || !(32'(rdata_q) < MAX_NODES);
	assign sts.at_root   = (cur_q == r_q);
	assign sts.clr_last  = (clr_q == NW'(MAX_NODES - 1));
	assign sts.last_item = last_q;

	// Read address select
	always_comb begin
		mem_re = cmd.find_start | cmd.find_step | cmd.comp_start | cmd.comp_step;
		if (cmd.find_start) begin
			raddr = start_node;
		end else if (cmd.comp_start) begin
			raddr = cur_q;
		end else begin
			raddr = rdata_q;
		end
	end

	// Write address and data select
	always_comb begin
		mem_we = 1'b0;
		waddr  = clr_q;
		wdata  = clr_q;
		if (cmd.clr_write) begin
			mem_we = 1'b1;
		end else if (cmd.comp_step) begin
			mem_we = 1'b1;
			waddr  = cur_q;
			wdata  = r_q;
		end else if (cmd.join_sets && roots_differ) begin
			mem_we = 1'b1;
			if (ra_q > r_q) begin
				waddr = ra_q;
				wdata = r_q;
			end else begin
				waddr = r_q;
				wdata = ra_q;
			end
		end
	end

	// Memory with registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[waddr] <= wdata;
		end
		if (mem_re) begin
			rdata_q <= mem[raddr];
		end
	end

	// Request, walk and result registers
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			w_q     <= edge_weight;
			a_q     <= node_a;
			b_q     <= node_b;
			last_q  <= last_edge;
			taken_q <= 1'b0;
		end
		if (cmd.find_start) begin
			r_q   <= start_node;
			cur_q <= start_node;
		end else if (cmd.find_step) begin
			r_q <= rdata_q;
		end else if (cmd.comp_step) begin
			cur_q <= rdata_q;
		end
		if (cmd.save_ra) begin
			ra_q <= r_q;
		end
		if (cmd.join_sets && roots_differ) begin
			taken_q <= 1'b1;
		end
		if (cmd.out_load) begin
			out_taken_q <= taken_q;
			out_total_q <= sum_q;
			out_done_q  <= last_q;
		end
	end

	// Clear counter and weight sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			sum_q <= '0;
		end else begin
			if (cmd.clr_start) begin
				clr_q <= '0;
				sum_q <= '0;
			end else begin
				if (cmd.clr_write) begin
					clr_q <= clr_q + NW'(1);
				end
				if (cmd.join_sets && roots_differ) begin
					sum_q <= sum_q + SUM_W'(w_q);
				end
			end
		end
	end

	assign edge_taken    = out_taken_q;
	assign running_total = out_total_q;
	assign graph_done    = out_done_q;

endmodule

// ----- rtl/kruskal_union_find_engine.sv -----
// Top level of the union-find engine for minimum spanning tree edge selection.
//
//  channel | handshake            | fields
//  --------+----------------------+---------------------------------------------
//  edge in | in_valid / in_ready  | edge_weight[19:0] node_a[8:0] node_b[8:0] last_edge
//  result  | out_valid / out_ready| edge_taken running_total[31:0] graph_done
//
// One edge is in flight at a time. Each edge walks La/Lb parent links to the two roots
// and repoints Ca/Cb nodes by path compression, one access of the parent memory per
// cycle.
// After reset and after each last edge the table is rewritten to identity, one entry
// per cycle, all MAX_NODES entries; no edge request is accepted meanwhile.
// A waiting result sits in an output register; the next edge is accepted and worked on
// while it waits, and only loading the next result stalls on out_ready.
module kruskal_union_find_engine #(
	parameter int MAX_NODES = 512
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [kufe_pkg::WEIGHT_W-1:0] edge_weight,
	input  logic [kufe_pkg::NODE_W-1:0]   node_a,
	input  logic [kufe_pkg::NODE_W-1:0]   node_b,
	input  logic                          last_edge,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          edge_taken,
	output logic [kufe_pkg::SUM_W-1:0]    running_total,
	output logic                          graph_done
);
	import kufe_pkg::*;

	kufe_cmd_t cmd;
	kufe_sts_t sts;

	kufe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	kufe_dpath #(
		.MAX_NODES (MAX_NODES)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.edge_weight   (edge_weight),
		.node_a        (node_a),
		.node_b        (node_b),
		.last_edge     (last_edge),
		.cmd           (cmd),
		.sts           (sts),
		.edge_taken    (edge_taken),
		.running_total (running_total),
		.graph_done    (graph_done)
	);

	// One edge at a time: busy right after a request is taken
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("engine ready again right after accepting an edge");

	// A pending result is never overwritten
	a_no_result_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid || out_ready))
		else $error("result register loaded while a result is pending");

	// At most one source drives the memory read address
	a_one_read_source: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.find_start, cmd.find_step, cmd.comp_start, cmd.comp_step}))
		else $error("conflicting memory read commands");

	// At most one writer to the parent memory
	a_one_writer: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.comp_step, cmd.join_sets, cmd.clr_write}))
		else $error("conflicting memory write commands");

endmodule
